// File: sv/lrf_pkg.sv
// Shared types and constants for the least rotation finder.
// Holds sizes, the datapath command set and the status bundle.
// No dependencies.
`default_nettype none

package lrf_pkg;

  localparam int MAX_LEN    = 64;
  localparam int SYM_BITS   = 8;
  localparam int IN_SYM_W   = 8;
  localparam int FAIL_DEPTH = 2 * MAX_LEN + 1;
  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  localparam int ADDR_W     = $clog2(MAX_LEN);
  localparam int POS_W      = $clog2(2 * MAX_LEN + 1);
  localparam int FIDX_W     = $clog2(FAIL_DEPTH);
  localparam int FVAL_W     = FIDX_W + 1;
  localparam int ROT_W      = 6;
  localparam int LEN_W      = 7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_RD_J,
    OP_LAT_J,
    OP_RD_CHK,
    OP_CMP,
    OP_LAT_I,
    OP_TAIL,
    OP_WR,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    logic i_neg;
    logic sym_eq;
    logic scan_end;
  } dp_status_t;

endpackage

`default_nettype wire

// File: sv/lrf_dp.sv
// Datapath of the least rotation finder: symbol store, failure table,
// scan registers and result registers. Driven by lrf_ctrl commands.
// Depends on lrf_pkg.
`default_nettype none

module lrf_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lrf_pkg::dp_op_e                 op_i,
  input  wire logic [lrf_pkg::IN_SYM_W-1:0]    symbol_i,
  output lrf_pkg::dp_status_t                  status_o,
  output logic [lrf_pkg::ROT_W-1:0]            rotation_start_o,
  output logic [lrf_pkg::LEN_W-1:0]            string_length_o,
  output logic                                 overflow_o
);

  localparam int PW = lrf_pkg::POS_W;
  localparam int FW = lrf_pkg::FIDX_W;
  localparam int VW = lrf_pkg::FVAL_W;

  function automatic logic [lrf_pkg::ADDR_W-1:0] mod_len(
    input logic [PW-1:0]                 v,
    input logic [lrf_pkg::CNT_W-1:0]     n
  );
    logic [PW-1:0] r;
    r = (v >= PW'(n)) ? v - PW'(n) : v;
    return lrf_pkg::ADDR_W'(r);
  endfunction

  logic [lrf_pkg::SYM_BITS-1:0] sym_mem [lrf_pkg::MAX_LEN];
  logic [VW-1:0]                fail_mem [lrf_pkg::FAIL_DEPTH];
  logic [lrf_pkg::FAIL_DEPTH-1:0] fvalid_q;

  logic [lrf_pkg::CNT_W-1:0]    count_q;
  logic                         ovf_q;
  logic [PW-1:0]                j_q;
  logic [PW-1:0]                k_q;
  logic [VW-1:0]                i_q;
  logic [VW-1:0]                wval_q;
  logic [lrf_pkg::SYM_BITS-1:0] sj_q;
  logic [lrf_pkg::SYM_BITS-1:0] sym_rd_q;
  logic [VW-1:0]                fail_rd_q;
  logic                         fvalid_rd_q;
  logic                         fneg_q;
  logic [lrf_pkg::ROT_W-1:0]    rot_q;
  logic [lrf_pkg::LEN_W-1:0]    len_q;
  logic                         ovf_res_q;

  logic [lrf_pkg::ADDR_W-1:0]   sym_raddr;
  logic [FW-1:0]                fail_raddr;
  logic [FW-1:0]                fail_waddr;
  logic [PW:0]                  jk_diff;
  logic [PW:0]                  j_nxt;
  logic [PW:0]                  two_n;
  logic [PW-1:0]                i_pos;
  logic [PW-1:0]                k_i_1;
  logic [PW-1:0]                j_i_1;
  logic [VW-1:0]                i_inc;
  logic                         sym_eq;
  logic                         sym_lt;

  assign i_pos   = PW'(i_q[FW-1:0]);
  assign k_i_1   = k_q + i_pos + PW'(1);
  assign j_i_1   = j_q - i_pos - PW'(1);
  assign i_inc   = {1'b0, i_q[FW-1:0] + FW'(1)};
  assign jk_diff = {1'b0, j_q} - {1'b0, k_q} - (PW+1)'(1);
  assign j_nxt   = {1'b0, j_q} + (PW+1)'(1);
  assign two_n   = (PW+1)'({count_q, 1'b0});
  assign fail_waddr = FW'(j_q - k_q);
  assign sym_eq  = (sj_q == sym_rd_q);
  assign sym_lt  = (sj_q < sym_rd_q);

  assign status_o.i_neg    = i_q[VW-1];
  assign status_o.sym_eq   = sym_eq;
  assign status_o.scan_end = (j_nxt >= two_n);

  always_comb begin
    sym_raddr  = mod_len(k_q, count_q);
    fail_raddr = FW'(jk_diff[PW-1:0]);
    if (op_i == lrf_pkg::OP_RD_J) begin
      sym_raddr = mod_len(j_q, count_q);
    end else if (op_i == lrf_pkg::OP_RD_CHK && !i_q[VW-1]) begin
      sym_raddr = mod_len(k_i_1, count_q);
    end
    if (op_i == lrf_pkg::OP_CMP) begin
      fail_raddr = i_q[FW-1:0];
    end
  end

  // storage arrays
  always_ff @(posedge clk_i) begin
    if (op_i == lrf_pkg::OP_LOAD && count_q < lrf_pkg::CNT_W'(lrf_pkg::MAX_LEN)) begin
      sym_mem[count_q[lrf_pkg::ADDR_W-1:0]] <= symbol_i[lrf_pkg::SYM_BITS-1:0];
    end
    sym_rd_q <= sym_mem[sym_raddr];
    if (op_i == lrf_pkg::OP_WR) begin
      fail_mem[fail_waddr] <= wval_q;
    end
    fail_rd_q <= fail_mem[fail_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q    <= '0;
      fvalid_rd_q <= 1'b0;
      fneg_q      <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      j_q         <= PW'(1);
      k_q         <= '0;
      i_q         <= '0;
    end else begin
      fvalid_rd_q <= fvalid_q[fail_raddr];
      fneg_q      <= jk_diff[PW];
      unique case (op_i)
        lrf_pkg::OP_LOAD: begin
          if (count_q < lrf_pkg::CNT_W'(lrf_pkg::MAX_LEN)) begin
            count_q <= count_q + lrf_pkg::CNT_W'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end
        lrf_pkg::OP_INIT: begin
          fvalid_q <= '0;
          j_q      <= PW'(1);
          k_q      <= '0;
        end
        lrf_pkg::OP_LAT_J: begin
          i_q <= (fneg_q || !fvalid_rd_q) ? '1 : fail_rd_q;
        end
        lrf_pkg::OP_CMP: begin
          if (!sym_eq && sym_lt) begin
            k_q <= j_i_1;
          end
        end
        lrf_pkg::OP_LAT_I: begin
          i_q <= fvalid_rd_q ? fail_rd_q : '1;
        end
        lrf_pkg::OP_TAIL: begin
          if (!sym_eq && sym_lt) begin
            k_q <= j_q;
          end
        end
        lrf_pkg::OP_WR: begin
          fvalid_q[fail_waddr] <= 1'b1;
          j_q <= j_nxt[PW-1:0];
        end
        lrf_pkg::OP_FIN: begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == lrf_pkg::OP_LAT_J) begin
      sj_q <= sym_rd_q[lrf_pkg::SYM_BITS-1:0];
    end
    if (op_i == lrf_pkg::OP_CMP) begin
      wval_q <= i_inc;
    end
    if (op_i == lrf_pkg::OP_TAIL) begin
      wval_q <= sym_eq ? i_inc : '1;
    end
    if (op_i == lrf_pkg::OP_FIN) begin
      rot_q     <= lrf_pkg::ROT_W'(mod_len(k_q, count_q));
      len_q     <= lrf_pkg::LEN_W'(count_q);
      ovf_res_q <= ovf_q;
    end
  end

  assign rotation_start_o = rot_q;
  assign string_length_o  = len_q;
  assign overflow_o       = ovf_res_q;

endmodule

`default_nettype wire

// File: sv/lrf_ctrl.sv
// Controller of the least rotation finder: sequences load, scan and
// result steps and issues datapath commands. Depends on lrf_pkg.
`default_nettype none

module lrf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  input  wire logic                last_i,
  input  wire lrf_pkg::dp_status_t status_i,
  output lrf_pkg::dp_op_e          op_o,
  output logic                     busy,
  output logic                     valid_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD_J,
    ST_LAT_J,
    ST_RD_CHK,
    ST_CMP,
    ST_LAT_I,
    ST_TAIL,
    ST_WR,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   valid_q;

  always_comb begin
    unique case (state_q)
      ST_IDLE:   op_o = start ? lrf_pkg::OP_LOAD : lrf_pkg::OP_NONE;
      ST_INIT:   op_o = lrf_pkg::OP_INIT;
      ST_RD_J:   op_o = lrf_pkg::OP_RD_J;
      ST_LAT_J:  op_o = lrf_pkg::OP_LAT_J;
      ST_RD_CHK: op_o = lrf_pkg::OP_RD_CHK;
      ST_CMP:    op_o = lrf_pkg::OP_CMP;
      ST_LAT_I:  op_o = lrf_pkg::OP_LAT_I;
      ST_TAIL:   op_o = lrf_pkg::OP_TAIL;
      ST_WR:     op_o = lrf_pkg::OP_WR;
      ST_FIN:    op_o = lrf_pkg::OP_FIN;
      default:   op_o = lrf_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start && last_i) begin
            state_q <= ST_INIT;
          end
        end
        ST_INIT:   state_q <= ST_RD_J;
        ST_RD_J:   state_q <= ST_LAT_J;
        ST_LAT_J:  state_q <= ST_RD_CHK;
        ST_RD_CHK: state_q <= status_i.i_neg ? ST_TAIL : ST_CMP;
        ST_CMP:    state_q <= status_i.sym_eq ? ST_WR : ST_LAT_I;
        ST_LAT_I:  state_q <= ST_RD_CHK;
        ST_TAIL:   state_q <= ST_WR;
        ST_WR:     state_q <= status_i.scan_end ? ST_FIN : ST_RD_J;
        ST_FIN: begin
          state_q <= ST_IDLE;
          valid_q <= 1'b1;
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: sv/least_rotation_finder.sv
// Least rotation finder top level: controller plus datapath.
// Loading: one symbol per cycle, busy stays low. On the last symbol the
// failure-function scan runs over 2n-1 positions, with fallback steps through
// the failure table (one read port each on the failure table and the store).
// Result strobe valid_o is registered in the ST_FIN state after the scan end.
// Reset clears control state; store contents are not cleared.
`default_nettype none

module least_rotation_finder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [lrf_pkg::IN_SYM_W-1:0] symbol_i,
  input  wire logic                         last_i,
  output logic                              valid_o,
  output logic [lrf_pkg::ROT_W-1:0]         rotation_start_o,
  output logic [lrf_pkg::LEN_W-1:0]         string_length_o,
  output logic                              overflow_o
);

  lrf_pkg::dp_op_e     op;
  lrf_pkg::dp_status_t status;

  lrf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .last_i   (last_i),
    .status_i (status),
    .op_o     (op),
    .busy     (busy),
    .valid_o  (valid_o)
  );

  lrf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .symbol_i         (symbol_i),
    .status_o         (status),
    .rotation_start_o (rotation_start_o),
    .string_length_o  (string_length_o),
    .overflow_o       (overflow_o)
  );

endmodule

`default_nettype wire

// File: dv/lrf_checker.sv
// Result checker for least_rotation_finder: watches the command and result
// ports, predicts each string's least rotation and compares every result.
// Depends on lrf_pkg for sizes and field widths.
module lrf_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [lrf_pkg::IN_SYM_W-1:0] symbol_i,
  input  logic                         last_i,
  input  logic                         valid_i,
  input  logic [lrf_pkg::ROT_W-1:0]    rotation_start_i,
  input  logic [lrf_pkg::LEN_W-1:0]    string_length_i,
  input  logic                         overflow_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import lrf_pkg::*;

  typedef struct packed {
    logic [ROT_W-1:0] rot;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } rot_result_t;

  logic [SYM_BITS-1:0] ring_sym  [MAX_LEN];
  int                  fail_link [FAIL_DEPTH];
  int                  sym_cnt  = 0;
  logic                ovf_seen = 1'b0;
  int                  fail_cnt = 0;
  rot_result_t         rot_q [$];
  rot_result_t         want;

  function automatic logic [SYM_BITS-1:0] ring_at(input int pos, input int n);
    return ring_sym[pos % n];
  endfunction

  function automatic int link_at(input int idx);
    return (idx >= 0 && idx < FAIL_DEPTH) ? fail_link[idx] : -1;
  endfunction

  // Booth scan over the doubled string, indices taken modulo n
  function automatic int least_rotation_of(input int n);
    int                  k;
    int                  i;
    logic [SYM_BITS-1:0] sj;
    k = 0;
    for (int t = 0; t < FAIL_DEPTH; t++) fail_link[t] = -1;
    for (int j = 1; j < 2 * n; j++) begin
      sj = ring_at(j, n);
      i  = link_at(j - k - 1);
      while (i != -1 && sj != ring_at(k + i + 1, n)) begin
        if (sj < ring_at(k + i + 1, n)) k = j - i - 1;
        i = link_at(i);
      end
      if (i == -1 && sj != ring_at(k, n)) begin
        if (sj < ring_at(k, n)) k = j;
        fail_link[j - k] = -1;
      end else begin
        fail_link[j - k] = i + 1;
      end
    end
    if (n <= 0 || k < 0) return 0;
    return k % n;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i) begin
        if (rot_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result rot=%0d len=%0d ovf=%0b", $time,
                   rotation_start_i, string_length_i, overflow_i);
        end else begin
          want = rot_q.pop_front();
          if (rotation_start_i !== want.rot) begin
            fail_cnt++;
            $display("%0t: rotation_start expected %0d actual %0d", $time,
                     want.rot, rotation_start_i);
          end
          if (string_length_i !== want.len) begin
            fail_cnt++;
            $display("%0t: string_length expected %0d actual %0d", $time,
                     want.len, string_length_i);
          end
          if (overflow_i !== want.ovf) begin
            fail_cnt++;
            $display("%0t: overflow expected %0b actual %0b", $time,
                     want.ovf, overflow_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        if (sym_cnt < MAX_LEN) begin
          ring_sym[sym_cnt] = symbol_i[SYM_BITS-1:0];
          sym_cnt++;
        end else begin
          ovf_seen = 1'b1;
        end
        if (last_i) begin
          want.rot = ROT_W'(least_rotation_of(sym_cnt));
          want.len = LEN_W'(sym_cnt);
          want.ovf = ovf_seen;
          rot_q.push_back(want);
          sym_cnt  = 0;
          ovf_seen = 1'b0;
        end
      end
    end
    fail_count_o <= fail_cnt;
    pending_o    <= rot_q.size();
  end

endmodule

// File: dv/tb_least_rotation_finder.sv
// Testbench top for least_rotation_finder: drives directed and random strings
// in bursts and gives the verdict from the lrf_checker failure and pending counts.
// Depends on lrf_pkg, lrf_checker and the block itself.
module tb_least_rotation_finder;
  import lrf_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [IN_SYM_W-1:0] symbol_i;
  logic                last_i;
  logic                valid_o;
  logic [ROT_W-1:0]    rotation_start_o;
  logic [LEN_W-1:0]    string_length_o;
  logic                overflow_o;

  int                  fail_count;
  int                  pending;
  int                  cycle_cnt  = 0;
  int                  items_sent = 0;
  int                  burst_left = 5;
  logic [IN_SYM_W-1:0] str_q [$];

  least_rotation_finder DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .symbol_i         (symbol_i),
    .last_i           (last_i),
    .valid_o          (valid_o),
    .rotation_start_o (rotation_start_o),
    .string_length_o  (string_length_o),
    .overflow_o       (overflow_o)
  );

  lrf_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .symbol_i         (symbol_i),
    .last_i           (last_i),
    .valid_i          (valid_o),
    .rotation_start_i (rotation_start_o),
    .string_length_i  (string_length_o),
    .overflow_i       (overflow_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic idle_gap();
    start    <= 1'b0;
    symbol_i <= IN_SYM_W'($urandom);
    last_i   <= 1'($urandom);
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                             : $urandom_range(1, 12);
  endtask

  // one transaction: hold start until the block takes it
  task automatic send_symbol(input logic [IN_SYM_W-1:0] sym, input logic lst);
    start    <= 1'b1;
    symbol_i <= sym;
    last_i   <= lst;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) idle_gap();
  endtask

  task automatic send_string();
    for (int t = 0; t < str_q.size(); t++) send_symbol(str_q[t], t == str_q.size() - 1);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic make_string();
    int                  len;
    int                  kind;
    int                  period;
    int                  r;
    logic [IN_SYM_W-1:0] pat [4];
    r = $urandom_range(0, 19);
    if (r < 12)      len = $urandom_range(1, 8);
    else if (r < 17) len = $urandom_range(9, 24);
    else if (r < 19) len = $urandom_range(25, 64);
    else             len = $urandom_range(64, 72);
    kind   = $urandom_range(0, 9);
    period = $urandom_range(1, 4);
    for (int p = 0; p < 4; p++) pat[p] = IN_SYM_W'($urandom);
    str_q.delete();
    for (int t = 0; t < len; t++) begin
      if (kind < 4)      str_q.push_back(IN_SYM_W'($urandom_range(0, 2)));
      else if (kind < 6) str_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
      else if (kind < 8) str_q.push_back(IN_SYM_W'($urandom));
      else               str_q.push_back(pat[t % period]);
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    symbol_i = '0;
    last_i   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single symbols at both extremes, then a short three-symbol string
    str_q = '{8'h00};                     send_string();
    str_q = '{8'hFF};                     send_string();
    str_q = '{8'h03, 8'h01, 8'h02};       send_string();
    // periodic strings (smallest of the tied starts), then mixed short cases
    str_q = '{8'h02, 8'h01, 8'h02, 8'h01}; send_string();
    str_q = '{8'h07, 8'h07, 8'h07};       send_string();
    str_q = '{8'hFF, 8'h00};              send_string();
    str_q = '{8'h05, 8'h04, 8'h03, 8'h02, 8'h01}; send_string();
    str_q = '{8'h80, 8'h7F, 8'h80, 8'h7F, 8'h01}; send_string();

    // hold off until every result is back
    drain();

    while (items_sent < ITEM_TARGET) begin
      make_string();
      send_string();
      if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
